// ===== src/escape_time_fractal_pixel_core_defines.svh =====
// Assertion macros shared by the escape-time fractal pixel core.
// Expects a clock i_clk and an active-low reset i_rst_n in the including scope.
`ifndef ESCAPE_TIME_FRACTAL_PIXEL_CORE_DEFINES_SVH
`define ESCAPE_TIME_FRACTAL_PIXEL_CORE_DEFINES_SVH

// same-cycle implication
`define ETF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("etf assertion failed");

// next-cycle implication
`define ETF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("etf assertion failed");

`endif

// ===== src/etf_pkg.sv =====
// Package for the escape-time fractal pixel core: widths, register indexes,
// configuration and control types. No dependencies.
package etf_pkg;

    localparam int COORD_W    = 32;
    localparam int FRAC_W     = COORD_W - 5;
    localparam int PIX_W      = 12;
    localparam int MAX_W      = 16;
    localparam int COUNT_W    = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CPROD_W    = COORD_W + PIX_W + 1;
    localparam int Z_W        = CPROD_W + 1;
    localparam int MUL_W      = FRAC_W + 2;
    localparam int SQ_W       = 2 * MUL_W;

    localparam logic [SQ_W-1:0] RADIUS_SQ = SQ_W'(1) << (2 * FRAC_W + 2);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEFT_RE  = 3'd0,
        CFG_TOP_IM   = 3'd1,
        CFG_STEP_RE  = 3'd2,
        CFG_STEP_IM  = 3'd3,
        CFG_MAX_ITER = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COORD_W-1:0] left_re;
        logic signed [COORD_W-1:0] top_im;
        logic signed [COORD_W-1:0] step_re;
        logic signed [COORD_W-1:0] step_im;
        logic [MAX_W-1:0]          max_iter;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMUL,
        S_CADD,
        S_SQUARE,
        S_UPDATE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load_pix;
        logic mul_c;
        logic init_z;
        logic square;
        logic update;
        logic push;
    } t_dp_cmd;

    typedef struct packed {
        logic iterate;
    } t_dp_sts;

endpackage

// ===== src/etf_cfg.sv =====
// Configuration register file of the escape-time fractal pixel core.
// Depends on etf_pkg.
module etf_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [etf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [etf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output etf_pkg::t_cfg                   o_cfg
);

    etf_pkg::t_cfg r_cfg;
    etf_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (etf_pkg::t_cfg_idx'(i_cfg_idx))
                etf_pkg::CFG_LEFT_RE:  n_cfg.left_re  = $signed(i_cfg_data[etf_pkg::COORD_W-1:0]);
                etf_pkg::CFG_TOP_IM:   n_cfg.top_im   = $signed(i_cfg_data[etf_pkg::COORD_W-1:0]);
                etf_pkg::CFG_STEP_RE:  n_cfg.step_re  = $signed(i_cfg_data[etf_pkg::COORD_W-1:0]);
                etf_pkg::CFG_STEP_IM:  n_cfg.step_im  = $signed(i_cfg_data[etf_pkg::COORD_W-1:0]);
                etf_pkg::CFG_MAX_ITER: n_cfg.max_iter = i_cfg_data[etf_pkg::MAX_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.left_re  <= '0;
            r_cfg.top_im   <= '0;
            r_cfg.step_re  <= '0;
            r_cfg.step_im  <= '0;
            r_cfg.max_iter <= etf_pkg::MAX_W'(255);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/etf_dp.sv =====
// Datapath of the escape-time fractal pixel core: point mapping, squaring,
// radius test, z update, iteration count and result register. Depends on etf_pkg.
module etf_dp (
    input  logic                                i_clk,
    input  etf_pkg::t_dp_cmd                    i_cmd,
    input  etf_pkg::t_cfg                       i_cfg,
    input  logic [etf_pkg::PIX_W-1:0]           i_pixel_x,
    input  logic [etf_pkg::PIX_W-1:0]           i_pixel_y,
    output etf_pkg::t_dp_sts                    o_sts,
    output logic signed [etf_pkg::COUNT_W-1:0]  o_escape_count
);

    localparam int HI_W = etf_pkg::Z_W - etf_pkg::FRAC_W - 1;

    // true when |z| < 2 in Q-format
    function automatic logic in_disc(input logic signed [etf_pkg::Z_W-1:0] z);
        logic [HI_W-1:0] hi;
        hi = z[etf_pkg::Z_W-1:etf_pkg::FRAC_W+1];
        return (~|hi) || ((&hi) && (z[etf_pkg::FRAC_W:0] != '0));
    endfunction

    logic [etf_pkg::PIX_W-1:0]          r_px;
    logic [etf_pkg::PIX_W-1:0]          r_py;
    logic signed [etf_pkg::CPROD_W-1:0] r_cprod_re;
    logic signed [etf_pkg::CPROD_W-1:0] r_cprod_im;
    logic signed [etf_pkg::Z_W-1:0]     r_cr;
    logic signed [etf_pkg::Z_W-1:0]     r_ci;
    logic signed [etf_pkg::Z_W-1:0]     r_zr;
    logic signed [etf_pkg::Z_W-1:0]     r_zi;
    logic signed [etf_pkg::SQ_W-1:0]    r_sq_re;
    logic signed [etf_pkg::SQ_W-1:0]    r_sq_im;
    logic signed [etf_pkg::SQ_W-1:0]    r_cross;
    logic                               r_big;
    logic signed [etf_pkg::COUNT_W-1:0] r_count;
    logic signed [etf_pkg::COUNT_W-1:0] r_out_count;

    logic signed [etf_pkg::Z_W-1:0]     n_cr;
    logic signed [etf_pkg::Z_W-1:0]     n_ci;
    logic signed [etf_pkg::Z_W-1:0]     n_zr;
    logic signed [etf_pkg::Z_W-1:0]     n_zi;
    logic signed [etf_pkg::MUL_W-1:0]   w_zr_m;
    logic signed [etf_pkg::MUL_W-1:0]   w_zi_m;
    logic signed [etf_pkg::SQ_W-1:0]    w_diff;
    logic signed [etf_pkg::SQ_W-1:0]    w_diff_sh;
    logic signed [etf_pkg::SQ_W-1:0]    w_cross_sh;
    logic [etf_pkg::SQ_W-1:0]           w_mag2;
    logic                               w_in_rad;
    logic                               w_below;

    assign n_cr = etf_pkg::Z_W'(i_cfg.left_re) + etf_pkg::Z_W'(r_cprod_re);
    assign n_ci = etf_pkg::Z_W'(i_cfg.top_im) + etf_pkg::Z_W'(r_cprod_im);

    assign w_zr_m = $signed(r_zr[etf_pkg::MUL_W-1:0]);
    assign w_zi_m = $signed(r_zi[etf_pkg::MUL_W-1:0]);

    // floor division by 2^FRAC_W; cross term carries the factor two
    assign w_diff     = r_sq_re - r_sq_im;
    assign w_diff_sh  = w_diff >>> etf_pkg::FRAC_W;
    assign w_cross_sh = r_cross >>> (etf_pkg::FRAC_W - 1);
    assign n_zr       = etf_pkg::Z_W'(w_diff_sh) + r_cr;
    assign n_zi       = etf_pkg::Z_W'(w_cross_sh) + r_ci;

    assign w_mag2   = $unsigned(r_sq_re) + $unsigned(r_sq_im);
    assign w_in_rad = !r_big && (w_mag2 < etf_pkg::RADIUS_SQ);
    assign w_below  = r_count < $signed({1'b0, i_cfg.max_iter});

    assign o_sts.iterate = w_in_rad && w_below;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pix) begin
            r_px <= i_pixel_x;
            r_py <= i_pixel_y;
        end
        if (i_cmd.mul_c) begin
            r_cprod_re <= etf_pkg::CPROD_W'(i_cfg.step_re)
                        * etf_pkg::CPROD_W'($signed({1'b0, r_px}));
            r_cprod_im <= etf_pkg::CPROD_W'(i_cfg.step_im)
                        * etf_pkg::CPROD_W'($signed({1'b0, r_py}));
        end
        if (i_cmd.init_z) begin
            r_cr    <= n_cr;
            r_ci    <= n_ci;
            r_zr    <= n_cr;
            r_zi    <= n_ci;
            r_count <= -etf_pkg::COUNT_W'(1);
        end
        if (i_cmd.square) begin
            r_sq_re <= etf_pkg::SQ_W'(w_zr_m) * etf_pkg::SQ_W'(w_zr_m);
            r_sq_im <= etf_pkg::SQ_W'(w_zi_m) * etf_pkg::SQ_W'(w_zi_m);
            r_cross <= etf_pkg::SQ_W'(w_zr_m) * etf_pkg::SQ_W'(w_zi_m);
            r_big   <= !(in_disc(r_zr) && in_disc(r_zi));
        end
        if (i_cmd.update) begin
            r_zr    <= n_zr;
            r_zi    <= n_zi;
            r_count <= r_count + etf_pkg::COUNT_W'(1);
        end
        if (i_cmd.push) begin
            r_out_count <= r_count;
        end
    end

    assign o_escape_count = r_out_count;

endmodule

// ===== src/etf_ctrl.sv =====
// Controller of the escape-time fractal pixel core: sequences one pixel
// through mapping and iteration and owns the handshakes. Depends on etf_pkg.
module etf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    input  etf_pkg::t_dp_sts  i_sts,
    output etf_pkg::t_dp_cmd  o_cmd
);

    etf_pkg::t_state r_state;
    etf_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= etf_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            etf_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_pix = 1'b1;
                    n_state        = etf_pkg::S_CMUL;
                end
            end
            etf_pkg::S_CMUL: begin
                o_cmd.mul_c = 1'b1;
                n_state     = etf_pkg::S_CADD;
            end
            etf_pkg::S_CADD: begin
                o_cmd.init_z = 1'b1;
                n_state      = etf_pkg::S_SQUARE;
            end
            etf_pkg::S_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = etf_pkg::S_UPDATE;
            end
            etf_pkg::S_UPDATE: begin
                if (i_sts.iterate) begin
                    o_cmd.update = 1'b1;
                    n_state      = etf_pkg::S_SQUARE;
                end else begin
                    n_state = etf_pkg::S_DONE;
                end
            end
            etf_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.push = 1'b1;
                    n_state    = etf_pkg::S_IDLE;
                end
            end
            default: n_state = etf_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.push) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== src/escape_time_fractal_pixel_core.sv =====
// Escape-time fractal pixel core, top level: configuration registers,
// controller and datapath. Depends on etf_pkg, etf_cfg, etf_ctrl, etf_dp and the defines header.
//
// Maps pixel (x, y) to c = (left_re + step_re*x) + i(top_im + step_im*y) in Q5.27,
// iterates z = z^2 + c from z = c while |z| < 2 and the count is below the iteration limit,
// and returns the count (-1 when c starts outside radius two). The core works on one
// pixel at a time: a pixel holds the input from its input beat until its result is pushed;
// each iteration runs the three 29x29 squaring multipliers, then the radius compare and
// z update. The result sits in an output register, so the next pixel is taken while a
// result waits; a finished pixel only stalls while the previous result is still not taken.
`include "escape_time_fractal_pixel_core_defines.svh"

module escape_time_fractal_pixel_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [etf_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [etf_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [etf_pkg::PIX_W-1:0]           i_pixel_x,
    input  logic [etf_pkg::PIX_W-1:0]           i_pixel_y,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [etf_pkg::COUNT_W-1:0]  o_escape_count
);

    etf_pkg::t_cfg    w_cfg;
    etf_pkg::t_dp_cmd w_cmd;
    etf_pkg::t_dp_sts w_sts;
    logic             w_count_ok;

    etf_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    etf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    etf_dp u_dp (
        .i_clk          (i_clk),
        .i_cmd          (w_cmd),
        .i_cfg          (w_cfg),
        .i_pixel_x      (i_pixel_x),
        .i_pixel_y      (i_pixel_y),
        .o_sts          (w_sts),
        .o_escape_count (o_escape_count)
    );

    assign w_count_ok = (o_escape_count >= $signed(-etf_pkg::COUNT_W'(1)))
                     && (o_escape_count <= $signed({1'b0, w_cfg.max_iter}));

    `ETF_ASSERT_NEXT(a_busy_after_beat, i_in_valid && o_in_ready, !o_in_ready)
    `ETF_ASSERT_NOW(a_no_result_overwrite, w_cmd.push, !o_out_valid || i_out_ready)
    `ETF_ASSERT_NOW(a_count_in_range, o_out_valid, w_count_ok)

endmodule
